// ----- hw/rtl/dfs_pkg.sv -----
// shared types, constants and state codes for the depth-first walk block
package dfs_pkg;

   localparam int MAX_VERTICES = 16;
   localparam int VTX_W        = $clog2(MAX_VERTICES);
   localparam int ROW_W        = 16;
   localparam int CNT_W        = 5;

   typedef logic [VTX_W-1:0] vtx_type;
   typedef logic [ROW_W-1:0] row_type;
   typedef logic [CNT_W-1:0] cnt_type;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_RUN  = 1'b1;

   localparam cnt_type COUNT_RESET = cnt_type'(16);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_POP,
      ST_FINISH
   } state_type;

endpackage

// ----- hw/rtl/dfs_req_if.sv -----
// request channel: row loads and run commands
interface dfs_req_if import dfs_pkg::*; ();
   logic    valid;
   logic    ready;
   logic    op;
   vtx_type row_index;
   row_type row_bits;

   modport source (output valid, output op, output row_index, output row_bits, input ready);
   modport sink   (input valid, input op, input row_index, input row_bits, output ready);
endinterface

// ----- hw/rtl/dfs_rsp_if.sv -----
// response channel: visited vertices in depth-first order
interface dfs_rsp_if import dfs_pkg::*; ();
   logic    valid;
   logic    ready;
   vtx_type vertex;
   logic    last;

   modport source (output valid, output vertex, output last, input ready);
   modport sink   (input valid, input vertex, input last, output ready);
endinterface

// ----- hw/rtl/dfs_adjacency_matrix_walk.sv -----
// depth-first walk over an adjacency matrix held in on-chip memory
//
// req_ch carries two kinds of item. A load item (op 0) writes one 16-bit
// adjacency row into the row memory and gives no response.
// A run item (op 1) clears the visited marks and walks depth-first from
// vertex 0, always taking the lowest-numbered unvisited neighbour of the
// vertex on top of the path stack and popping back when there is none.
// rsp_ch returns each reached vertex once, in visit order; the final one has
// last set. csr_we/csr_wdata write the vertex count (0 acts as 1, above 16
// acts as 16); write it only while no walk is running.
// Each vertex is held back until the next one is found or the walk ends, so
// a vertex leaves the block one discovery later. A forward step reads the
// row memory, then evaluates; a backtrack evaluates, reads the stack memory,
// then reads the row memory. The request side takes no new item until a run
// has handed over its last vertex. When the receiver stalls, the walk pauses
// at its next found vertex, with the result held in the output register.
// Reset clears the visited marks, the stack depth, the output valid flag and
// the per-row written flags, so every adjacency row reads as empty until
// loaded, and sets the vertex count to 16.
module dfs_adjacency_matrix_walk import dfs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  cnt_type      csr_wdata,
   dfs_req_if.sink      req_ch,
   dfs_rsp_if.source    rsp_ch
);

   state_type state_ff, state_in;
   cnt_type   count_ff;
   row_type   visited_ff, visited_in;
   cnt_type   depth_ff, depth_in;
   vtx_type   top_ff, top_in;
   vtx_type   pend_ff, pend_in;
   logic      rsp_valid_ff, rsp_valid_in;
   vtx_type   rsp_vertex_ff, rsp_vertex_in;
   logic      rsp_last_ff, rsp_last_in;
   row_type   row_vld_ff, row_vld_in;

   row_type   adj_mem [MAX_VERTICES];
   row_type   adj_q;
   logic      adj_vld_q;
   row_type   adj_row;
   vtx_type   stack_mem [MAX_VERTICES];
   vtx_type   stack_q;

   logic      adj_rd_en;
   logic      stack_we;
   vtx_type   stack_wa;
   vtx_type   stack_wd;
   logic      stack_rd_en;
   vtx_type   stack_ra;
   cnt_type   pop_idx;

   cnt_type   live_n;
   row_type   all_mask;
   row_type   cand;
   vtx_type   nb;
   row_type   nb_bit;
   logic      can_emit;
   logic      req_fire;
   logic      emit;
   vtx_type   emit_vertex;
   logic      emit_last;

   // live vertex count and mask
   always_comb begin
      if (count_ff == '0) begin
         live_n = cnt_type'(1);
      end else if (count_ff > cnt_type'(MAX_VERTICES)) begin
         live_n = cnt_type'(MAX_VERTICES);
      end else begin
         live_n = count_ff;
      end
      for (int j = 0; j < ROW_W; j++) begin
         all_mask[j] = (cnt_type'(j) < live_n);
      end
   end

   // rows never loaded read as empty
   assign adj_row = adj_vld_q ? adj_q : '0;

   // lowest unvisited neighbour
   always_comb begin
      cand = adj_row & ~visited_ff & all_mask;
      nb   = '0;
      for (int j = ROW_W - 1; j >= 0; j--) begin
         if (cand[j]) begin
            nb = vtx_type'(j);
         end
      end
      nb_bit = row_type'(1) << nb;
   end

   assign can_emit     = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE) && can_emit;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign pop_idx      = depth_ff - cnt_type'(2);

   // written flags of the row memory
   always_comb begin
      row_vld_in = row_vld_ff;
      if (req_fire && req_ch.op == OP_LOAD) begin
         row_vld_in[req_ch.row_index] = 1'b1;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_ch.op == OP_RUN) begin
               state_in = (live_n == cnt_type'(1)) ? ST_FINISH : ST_READ;
            end
         end
         ST_READ: state_in = ST_EVAL;
         ST_EVAL: begin
            if (cand != '0) begin
               if (can_emit) begin
                  state_in = (((visited_ff | nb_bit) & all_mask) == all_mask) ?
                             ST_FINISH : ST_READ;
               end
            end else begin
               state_in = (depth_ff == cnt_type'(1)) ? ST_FINISH : ST_POP;
            end
         end
         ST_POP: state_in = ST_READ;
         ST_FINISH: begin
            if (can_emit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      visited_in  = visited_ff;
      depth_in    = depth_ff;
      top_in      = top_ff;
      pend_in     = pend_ff;
      adj_rd_en   = 1'b0;
      stack_we    = 1'b0;
      stack_wa    = depth_ff[VTX_W-1:0];
      stack_wd    = nb;
      stack_rd_en = 1'b0;
      stack_ra    = pop_idx[VTX_W-1:0];
      emit        = 1'b0;
      emit_vertex = pend_ff;
      emit_last   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_ch.op == OP_RUN) begin
               visited_in = row_type'(1);
               depth_in   = cnt_type'(1);
               top_in     = '0;
               pend_in    = '0;
               stack_we   = 1'b1;
               stack_wa   = '0;
               stack_wd   = '0;
            end
         end
         ST_READ: adj_rd_en = 1'b1;
         ST_EVAL: begin
            if (cand != '0) begin
               if (can_emit) begin
                  visited_in = visited_ff | nb_bit;
                  stack_we   = 1'b1;
                  depth_in   = depth_ff + cnt_type'(1);
                  top_in     = nb;
                  pend_in    = nb;
                  emit       = 1'b1;
               end
            end else begin
               depth_in    = depth_ff - cnt_type'(1);
               stack_rd_en = (depth_ff != cnt_type'(1));
            end
         end
         ST_POP: top_in = stack_q;
         ST_FINISH: begin
            if (can_emit) begin
               emit      = 1'b1;
               emit_last = 1'b1;
            end
         end
         default: ;
      endcase

      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_vertex_in = emit_vertex;
         rsp_last_in   = emit_last;
      end else begin
         rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
         rsp_vertex_in = rsp_vertex_ff;
         rsp_last_in   = rsp_last_ff;
      end
   end

   // row memory
   always_ff @(posedge clock) begin
      if (req_fire && req_ch.op == OP_LOAD) begin
         adj_mem[req_ch.row_index] <= req_ch.row_bits;
      end
      if (adj_rd_en) begin
         adj_q     <= adj_mem[top_ff];
         adj_vld_q <= row_vld_ff[top_ff];
      end
   end

   // path stack memory
   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_wa] <= stack_wd;
      end
      if (stack_rd_en) begin
         stack_q <= stack_mem[stack_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= COUNT_RESET;
         visited_ff   <= '0;
         depth_ff     <= '0;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         row_vld_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         visited_ff   <= visited_in;
         depth_ff     <= depth_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         row_vld_ff   <= row_vld_in;
         if (csr_we) begin
            count_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      top_ff        <= top_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.vertex = rsp_vertex_ff;
   assign rsp_ch.last   = rsp_last_ff;

endmodule
